// ===== rtl/dasd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Date stepper package
// Constants and small lookup functions shared by the date add/subtract block.
// ----------------------------------------------------------------------------
package dasd_pkg;

    localparam logic [9:0]  MAX_DAY_COUNT = 10'd999;

    // Reciprocals for division by constants through the shared multiplier.
    // The product is taken for operands below 2**15, where both are exact.
    localparam logic [14:0] RECIP_100 = 15'd5243;   // floor(y / 100) = (y * K) >> 19
    localparam logic [14:0] RECIP_7   = 15'd18725;  // floor(s / 7)   = (s * K) >> 17

    localparam logic [3:0]  MONTH_JAN = 4'd1;
    localparam logic [3:0]  MONTH_FEB = 4'd2;
    localparam logic [3:0]  MONTH_MAR = 4'd3;
    localparam logic [3:0]  MONTH_DEC = 4'd12;

    localparam logic        OP_ADD = 1'b0;
    localparam logic        OP_SUB = 1'b1;

    // Number of days in month m (1..12), with February following the leap flag.
    function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
        logic [4:0] len;
        begin
            unique case (m)
                4'd2:    len = leap ? 5'd29 : 5'd28;
                4'd4:    len = 5'd30;
                4'd6:    len = 5'd30;
                4'd9:    len = 5'd30;
                4'd11:   len = 5'd30;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

    // The term 3 * (m + 1) / 5 for the adjusted month 3..14.
    function automatic logic [3:0] month_term(input logic [3:0] m);
        logic [3:0] t;
        begin
            unique case (m)
                4'd3:    t = 4'd2;
                4'd4:    t = 4'd3;
                4'd5:    t = 4'd3;
                4'd6:    t = 4'd4;
                4'd7:    t = 4'd4;
                4'd8:    t = 4'd5;
                4'd9:    t = 4'd6;
                4'd10:   t = 4'd6;
                4'd11:   t = 4'd7;
                4'd12:   t = 4'd7;
                4'd13:   t = 4'd8;
                4'd14:   t = 4'd9;
                default: t = 4'd0;
            endcase
            return t;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/date_add_subtract_days_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Date add/subtract days
// Steps a Gregorian date forward or backward by a day count and reports the
// resulting date together with its weekday (0 = Monday).
// ----------------------------------------------------------------------------
// From the input transfer until the result is presented, an item passes through
// ST_PREP and ST_LEAP, which derive the year's position in the 100 and 400
// year cycles, then ST_STEP, where the day stepper moves one day per cycle
// until the walk ends (day_count is limited to 999, and a backward walk ends
// early in year 1), and then ST_WK_DIV, ST_WK_SUM, ST_WK_MOD and ST_WK_FIN,
// the weekday arithmetic on the single shared 15 x 15 bit multiplier. The
// input is held off while an item is in work; a finished result sits in the
// output register, so the next item may be taken while it waits for its transfer.
module date_add_subtract_days_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_operation,
    input  wire logic [4:0]  s_start_day,
    input  wire logic [3:0]  s_start_month,
    input  wire logic [13:0] s_start_year,
    input  wire logic [9:0]  s_day_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [4:0]       m_result_day,
    output logic [3:0]       m_result_month,
    output logic [13:0]      m_result_year,
    output logic [2:0]       m_weekday
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_LEAP,
        ST_STEP,
        ST_WK_DIV,
        ST_WK_SUM,
        ST_WK_MOD,
        ST_WK_FIN
    } state_t;

    state_t      state_reg;
    logic        op_reg;
    logic [4:0]  d_reg;
    logic [3:0]  m_reg;
    logic [14:0] y_reg;
    logic [9:0]  cnt_reg;
    logic [6:0]  mod100_reg;
    logic [8:0]  mod400_reg;
    logic [28:0] prod_reg;
    logic [14:0] s_reg;
    logic        m_valid_reg;
    logic [4:0]  res_day_reg;
    logic [3:0]  res_month_reg;
    logic [13:0] res_year_reg;
    logic [2:0]  weekday_reg;

    logic [14:0] mul_a;
    logic [14:0] mul_b;
    logic [28:0] mul_prod;
    logic        leap;
    logic [4:0]  cur_len;
    logic [4:0]  prev_len;
    logic [5:0]  d_inc;
    logic        before_march;
    logic [14:0] wk_y;
    logic [3:0]  wk_m;
    logic [7:0]  q100;
    logic [5:0]  q400;
    logic [6:0]  mod100_calc;
    logic [8:0]  mod400_calc;
    logic [14:0] wk_sum;
    logic [11:0] q7;
    logic [14:0] mul7;
    logic [14:0] rem7;
    logic        step_done;
    logic        out_free;

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_day   = res_day_reg;
    assign m_result_month = res_month_reg;
    assign m_result_year  = res_year_reg;
    assign m_weekday      = weekday_reg;

    // Shared multiplier: year by the reciprocal of 100, or sum by that of 7.
    always_comb begin
        unique case (state_reg)
            ST_WK_DIV: begin
                mul_a = wk_y;
                mul_b = dasd_pkg::RECIP_100;
            end
            ST_WK_MOD: begin
                mul_a = s_reg;
                mul_b = dasd_pkg::RECIP_7;
            end
            default: begin
                mul_a = y_reg;
                mul_b = dasd_pkg::RECIP_100;
            end
        endcase
    end
    assign mul_prod = 29'(mul_a) * 29'(mul_b);

    // The year's residues modulo 100 and 400 are tracked as it changes by one.
    assign leap     = ((y_reg[1:0] == 2'b00) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign cur_len  = dasd_pkg::month_len(m_reg, leap);
    assign prev_len = dasd_pkg::month_len(m_reg - 4'd1, leap);
    assign d_inc    = {1'b0, d_reg} + 6'd1;

    assign before_march = (m_reg < dasd_pkg::MONTH_MAR);
    assign wk_y         = before_march ? (y_reg - 15'd1) : y_reg;
    assign wk_m         = before_march ? (m_reg + 4'd12) : m_reg;

    assign q100        = prod_reg[26:19];
    assign q400        = q100[7:2];
    assign mod100_calc = 7'(y_reg - (15'(q100) * 15'd100));
    assign mod400_calc = 9'(y_reg - (15'(q400) * 15'd400));

    assign wk_sum = 15'(d_reg) + {10'd0, wk_m, 1'b0} + 15'(dasd_pkg::month_term(wk_m))
                  + wk_y + 15'(wk_y[14:2]) + 15'(q400) - 15'(q100);

    assign q7   = prod_reg[28:17];
    assign mul7 = {q7, 3'b000} - 15'(q7);
    assign rem7 = s_reg - mul7;

    assign step_done = (cnt_reg == 10'd0)
                     || ((op_reg == dasd_pkg::OP_SUB) && (y_reg == 15'd1));
    assign out_free  = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_WK_FIN)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg  <= s_operation;
                        d_reg   <= (s_start_day == 5'd0) ? 5'd1 : s_start_day;
                        m_reg   <= (s_start_month == 4'd0) ? 4'd1 :
                                   (s_start_month > dasd_pkg::MONTH_DEC) ? dasd_pkg::MONTH_DEC :
                                   s_start_month;
                        y_reg   <= (s_start_year == 14'd0) ? 15'd1 : {1'b0, s_start_year};
                        cnt_reg <= (s_day_count > dasd_pkg::MAX_DAY_COUNT) ?
                                   dasd_pkg::MAX_DAY_COUNT : s_day_count;
                        state_reg <= ST_PREP;
                    end
                end
                ST_PREP: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_LEAP;
                end
                ST_LEAP: begin
                    mod100_reg <= mod100_calc;
                    mod400_reg <= mod400_calc;
                    state_reg  <= ST_STEP;
                end
                ST_STEP: begin
                    if (step_done) begin
                        state_reg <= ST_WK_DIV;
                    end else begin
                        cnt_reg <= cnt_reg - 10'd1;
                        if (op_reg == dasd_pkg::OP_ADD) begin
                            if (d_inc > {1'b0, cur_len}) begin
                                d_reg <= 5'd1;
                                if (m_reg == dasd_pkg::MONTH_DEC) begin
                                    m_reg      <= 4'd1;
                                    y_reg      <= y_reg + 15'd1;
                                    mod100_reg <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
                                    mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
                                end else begin
                                    m_reg <= m_reg + 4'd1;
                                end
                            end else begin
                                d_reg <= d_inc[4:0];
                            end
                        end else begin
                            if (d_reg == 5'd1) begin
                                if (m_reg == 4'd1) begin
                                    d_reg      <= 5'd31;
                                    m_reg      <= dasd_pkg::MONTH_DEC;
                                    y_reg      <= y_reg - 15'd1;
                                    mod100_reg <= (mod100_reg == 7'd0) ? 7'd99 : mod100_reg - 7'd1;
                                    mod400_reg <= (mod400_reg == 9'd0) ? 9'd399 : mod400_reg - 9'd1;
                                end else begin
                                    d_reg <= prev_len;
                                    m_reg <= m_reg - 4'd1;
                                end
                            end else begin
                                d_reg <= d_reg - 5'd1;
                            end
                        end
                    end
                end
                ST_WK_DIV: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_WK_SUM;
                end
                ST_WK_SUM: begin
                    s_reg     <= wk_sum;
                    state_reg <= ST_WK_MOD;
                end
                ST_WK_MOD: begin
                    prod_reg  <= mul_prod;
                    state_reg <= ST_WK_FIN;
                end
                ST_WK_FIN: begin
                    // Hold here while an earlier result still waits for its transfer.
                    if (out_free) begin
                        res_day_reg   <= d_reg;
                        res_month_reg <= m_reg;
                        res_year_reg  <= y_reg[13:0];
                        weekday_reg   <= rem7[2:0];
                        m_valid_reg   <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire
